### design/spq_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// spq_pkg
// Shared constants, codes and types of the sorted priority queue.
// ---------------------------------------------------------------------------
package spq_pkg;

    localparam int DEPTH_DEF     = 16;
    localparam int KEY_WIDTH_DEF = 32;

    // Action codes on the command port
    localparam logic [1:0] ACT_INSERT = 2'd0;
    localparam logic [1:0] ACT_REMOVE = 2'd1;
    localparam logic [1:0] ACT_DUMP   = 2'd2;

    // Result status codes
    localparam logic [1:0] STAT_OK         = 2'd0;
    localparam logic [1:0] STAT_UNDERFLOW  = 2'd1;
    localparam logic [1:0] STAT_OVERFLOW   = 2'd2;
    localparam logic [1:0] STAT_EMPTY_DUMP = 2'd3;

    typedef logic [2:0] dp_op_t;

    // Datapath operations issued by the controller
    localparam dp_op_t DP_NOP        = 3'd0;
    localparam dp_op_t DP_INSERT     = 3'd1;
    localparam dp_op_t DP_REMOVE     = 3'd2;
    localparam dp_op_t DP_OVERFLOW   = 3'd3;
    localparam dp_op_t DP_UNDERFLOW  = 3'd4;
    localparam dp_op_t DP_DUMP_EMPTY = 3'd5;
    localparam dp_op_t DP_DUMP_START = 3'd6;
    localparam dp_op_t DP_DUMP_NEXT  = 3'd7;

    // Datapath status seen by the controller
    typedef struct packed {
        logic empty;     // no key stored
        logic full;      // DEPTH keys stored
        logic single;    // exactly one key stored
        logic idx_last;  // dump pointer is on the final stored key
    } dp_status_t;

endpackage

### design/spq_datapath.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// spq_datapath
// Row of compare-and-shift key cells, key count, dump pointer and the
// registered result ports.
// ---------------------------------------------------------------------------
module spq_datapath
    import spq_pkg::*;
#(
    parameter int DEPTH     = DEPTH_DEF,
    parameter int KEY_WIDTH = KEY_WIDTH_DEF,
    parameter int CNT_W     = $clog2(DEPTH + 1)
)
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  dp_op_t                      op,
    input  logic signed [KEY_WIDTH-1:0] key,
    output dp_status_t                  dp_status,
    output logic                        result_valid,
    output logic        [1:0]           status,
    output logic signed [KEY_WIDTH-1:0] key_out,
    output logic        [CNT_W-1:0]     count,
    output logic                        last
);

    localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    logic signed [KEY_WIDTH-1:0] keys_reg  [DEPTH];
    logic signed [KEY_WIDTH-1:0] keys_next [DEPTH];
    logic signed [KEY_WIDTH-1:0] prev_key  [DEPTH];
    logic signed [KEY_WIDTH-1:0] up_key    [DEPTH];
    logic        [DEPTH-1:0]     gt;
    logic        [DEPTH-1:0]     prev_gt;

    logic [CNT_W-1:0] count_reg, count_next;
    logic [IDX_W-1:0] idx_reg, idx_next;
    logic [IDX_W-1:0] rd_idx;

    logic                        valid_reg, valid_next;
    logic [1:0]                  status_reg, status_next;
    logic signed [KEY_WIDTH-1:0] key_out_reg, key_out_next;
    logic [CNT_W-1:0]            cnt_out_reg, cnt_out_next;
    logic                        last_reg, last_next;

    // Each cell compares its own key with the new key; sorted order makes
    // gt a thermometer code over the valid cells.
    genvar g;
    generate
        for (g = 0; g < DEPTH; g++)
        begin : g_cell
            assign gt[g] = (CNT_W'(g) < count_reg) && (keys_reg[g] > key);

            if (g == 0)
            begin : g_head
                assign prev_gt[g]  = 1'b0;
                assign prev_key[g] = keys_reg[g];
            end
            else
            begin : g_body
                assign prev_gt[g]  = gt[g-1];
                assign prev_key[g] = keys_reg[g-1];
            end

            if (g == DEPTH - 1)
            begin : g_tail
                assign up_key[g] = keys_reg[g];
            end
            else
            begin : g_inner
                assign up_key[g] = keys_reg[g+1];
            end

            always_comb
            begin
                keys_next[g] = keys_reg[g];
                case (op)
                    DP_INSERT:
                    begin
                        if (CNT_W'(g) <= count_reg)
                        begin
                            if (prev_gt[g])
                                keys_next[g] = prev_key[g];
                            else if (gt[g] || (CNT_W'(g) == count_reg))
                                keys_next[g] = key;
                        end
                    end
                    DP_REMOVE:
                        keys_next[g] = up_key[g];
                    default:
                        keys_next[g] = keys_reg[g];
                endcase
            end
        end
    endgenerate

    assign dp_status.empty    = (count_reg == '0);
    assign dp_status.full     = (count_reg == CNT_W'(DEPTH));
    assign dp_status.single   = (count_reg == CNT_W'(1));
    assign dp_status.idx_last = ((CNT_W'(idx_reg) + CNT_W'(1)) == count_reg);

    assign rd_idx = (op == DP_DUMP_START) ? '0 : idx_reg;

    always_comb
    begin
        count_next   = count_reg;
        idx_next     = idx_reg;
        valid_next   = 1'b1;
        status_next  = STAT_OK;
        key_out_next = '0;
        last_next    = 1'b1;
        case (op)
            DP_INSERT:
                count_next = count_reg + CNT_W'(1);
            DP_REMOVE:
            begin
                count_next   = count_reg - CNT_W'(1);
                key_out_next = keys_reg[0];
            end
            DP_OVERFLOW:
                status_next = STAT_OVERFLOW;
            DP_UNDERFLOW:
                status_next = STAT_UNDERFLOW;
            DP_DUMP_EMPTY:
                status_next = STAT_EMPTY_DUMP;
            DP_DUMP_START, DP_DUMP_NEXT:
            begin
                key_out_next = keys_reg[rd_idx];
                last_next    = (op == DP_DUMP_START) ? dp_status.single
                                                     : dp_status.idx_last;
                idx_next     = rd_idx + IDX_W'(1);
            end
            default:
            begin
                valid_next = 1'b0;
                last_next  = 1'b0;
            end
        endcase
        cnt_out_next = count_next;
    end

    always_ff @(posedge clk)
    begin
        keys_reg <= keys_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            idx_reg   <= '0;
            valid_reg <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            idx_reg   <= idx_next;
            valid_reg <= valid_next;
        end
    end

    // Hold result payload only when a result is produced
    always_ff @(posedge clk)
    begin
        if (valid_next)
        begin
            status_reg  <= status_next;
            key_out_reg <= key_out_next;
            cnt_out_reg <= cnt_out_next;
            last_reg    <= last_next;
        end
    end

    assign result_valid = valid_reg;
    assign status       = status_reg;
    assign key_out      = key_out_reg;
    assign count        = cnt_out_reg;
    assign last         = last_reg;

endmodule

### design/spq_controller.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// spq_controller
// Decodes accepted transactions into datapath operations and sequences
// the multi-cycle dump.
// ---------------------------------------------------------------------------
module spq_controller
    import spq_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       start,
    input  logic [1:0] action,
    input  dp_status_t dp_status,
    output dp_op_t     op,
    output logic       busy
);

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_DUMP = 1'b1;

    logic state_reg, state_next;

    assign busy = (state_reg == ST_DUMP);

    always_comb
    begin
        op         = DP_NOP;
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    case (action)
                        ACT_INSERT:
                            op = dp_status.full ? DP_OVERFLOW : DP_INSERT;
                        ACT_REMOVE:
                            op = dp_status.empty ? DP_UNDERFLOW : DP_REMOVE;
                        ACT_DUMP:
                        begin
                            if (dp_status.empty)
                                op = DP_DUMP_EMPTY;
                            else
                            begin
                                op = DP_DUMP_START;
                                if (!dp_status.single)
                                    state_next = ST_DUMP;
                            end
                        end
                        default:
                            op = DP_NOP;  // undefined action: drop it
                    endcase
                end
            end
            ST_DUMP:
            begin
                op = DP_DUMP_NEXT;
                if (dp_status.idx_last)
                    state_next = ST_IDLE;
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

endmodule

### design/sorted_priority_queue_unit.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// sorted_priority_queue_unit
// Min priority queue of up to DEPTH signed keys kept in nondecreasing order.
// The first result appears in the cycle after its transaction is accepted;
// further dump keys follow one per cycle. Insert and remove are done by
// the compare-and-shift key row and never raise busy; a dump of more than
// one key keeps busy high until its final key is emitted, and emits one key
// per cycle. Results cannot be stalled by the receiver.
// Reset clears the key count and control state; key cells are not cleared.
// ---------------------------------------------------------------------------
module sorted_priority_queue_unit
    import spq_pkg::*;
#(
    parameter int DEPTH     = DEPTH_DEF,
    parameter int KEY_WIDTH = KEY_WIDTH_DEF,
    parameter int CNT_W     = $clog2(DEPTH + 1)
)
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    output logic                        busy,
    input  logic        [1:0]           action,
    input  logic signed [KEY_WIDTH-1:0] key,
    output logic                        result_valid,
    output logic        [1:0]           status,
    output logic signed [KEY_WIDTH-1:0] key_out,
    output logic        [CNT_W-1:0]     count,
    output logic                        last
);

    dp_op_t     op;
    dp_status_t dp_status;

    spq_controller u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .action    (action),
        .dp_status (dp_status),
        .op        (op),
        .busy      (busy)
    );

    spq_datapath
    #(
        .DEPTH     (DEPTH),
        .KEY_WIDTH (KEY_WIDTH),
        .CNT_W     (CNT_W)
    )
    u_dp
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .op           (op),
        .key          (key),
        .dp_status    (dp_status),
        .result_valid (result_valid),
        .status       (status),
        .key_out      (key_out),
        .count        (count),
        .last         (last)
    );

endmodule
